FILE: hdl/skf_pkg.sv
`timescale 1ns / 1ps

package skf_pkg;

   // default data format: Q16.16
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT  = 16;

   // register reset values
   localparam longint unsigned PROCESS_NOISE_RESET     = 655;
   localparam longint unsigned MEASUREMENT_NOISE_RESET = 65536;
   localparam longint unsigned INITIAL_ESTIMATE_RESET  = 0;
   localparam longint unsigned INITIAL_ERROR_RESET     = 65536;

   // register indexes
   localparam int REG_INDEX_WIDTH = 2;
   typedef logic [REG_INDEX_WIDTH-1:0] reg_index_type;

   localparam reg_index_type REG_PROCESS_NOISE     = 2'd0;
   localparam reg_index_type REG_MEASUREMENT_NOISE = 2'd1;
   localparam reg_index_type REG_INITIAL_ESTIMATE  = 2'd2;
   localparam reg_index_type REG_INITIAL_ERROR     = 2'd3;

endpackage

FILE: hdl/skf_req_if.sv
`timescale 1ns / 1ps

interface skf_req_if #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] measurement;

   modport source (output valid, output measurement, input ready);
   modport sink (input valid, input measurement, output ready);
endinterface

FILE: hdl/skf_rsp_if.sv
`timescale 1ns / 1ps

interface skf_rsp_if #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] estimate;
   logic                         saturated;

   modport source (output valid, output estimate, output saturated, input ready);
   modport sink (input valid, input estimate, input saturated, output ready);
endinterface

FILE: hdl/scalar_kalman_filter.sv
`timescale 1ns / 1ps

// one-dimensional kalman filter, fixed point (Q16.16 at the defaults)
// req_if : one beat carries one measurement; accepted when valid and ready are high
// rsp_if : one beat per measurement carrying the updated estimate and a saturation flag
// csr_*  : apb-style register port, registers at 4*i (8*i when DATA_WIDTH > 32):
//          process noise q, measurement noise r, initial estimate, initial error
//          registers are to be written only while the filter is idle; not enforced
// timing : one item at a time; the gain is found by a restoring divider that
//          yields one quotient bit per cycle, then both products are formed by
//          a shift-add multiplier taking one gain bit per cycle. the divider
//          is skipped when r is 0, the gain then being 0 or 1.0; a new beat is taken
//          in the cycle after the result is registered
// reset  : registers return to their reset values; the first measurement after
//          reset starts from the initial estimate and initial error registers
// stall  : the result sits in an output register while rsp ready is low; the
//          filter finishes its next item and then holds it until the
//          output register frees up
module scalar_kalman_filter #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT,
   parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   skf_req_if.sink                                  req_if,
   skf_rsp_if.source                                rsp_if,
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [((DATA_WIDTH > 32) ? 5 : 4)-1:0]   csr_paddr,
   input  logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] csr_pwdata,
   output logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] csr_prdata,
   output logic                                     csr_pready
);
   import skf_pkg::*;

   localparam int W       = DATA_WIDTH;
   localparam int F       = FRAC_BITS;
   localparam int CSR_DW  = (DATA_WIDTH > 32) ? 64 : 32;
   localparam int CSR_AW  = (DATA_WIDTH > 32) ? 5 : 4;
   localparam int CW      = $clog2(FRAC_BITS + 1);

   // sequencer codes
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEN  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_MSET = 3'd3;
   localparam logic [2:0] S_MUL  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   // gain of exactly 1.0
   localparam logic [F:0] GAIN_ONE = {1'b1, {F{1'b0}}};

   // ---------------------------------------------------------------- registers
   logic [W-1:0] q_ff, q_in;
   logic [W-1:0] r_ff, r_in;
   logic [W-1:0] init_x_ff, init_x_in;
   logic [W-1:0] init_p_ff, init_p_in;

   // ---------------------------------------------------------------- datapath
   logic [2:0]          state_ff, state_in;
   logic                started_ff, started_in;
   logic signed [W-1:0] x_ff, x_in;           // current estimate
   logic [W-1:0]        p_ff, p_in;           // error covariance
   logic [W-1:0]        p1_ff, p1_in;         // predicted covariance
   logic                sat_ff, sat_in;
   logic signed [W:0]   inn_ff, inn_in;       // innovation m - x
   logic [W:0]          den_ff, den_in;       // p1 + r
   logic [W:0]          rem_ff, rem_in;       // divider remainder
   logic [F:0]          gain_ff, gain_in;     // gain, shifts out lsb first while multiplying
   logic [F:0]          comp_ff, comp_in;     // 1 - gain
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic signed [W+1:0] accx_ff, accx_in;     // upper part of gain * innovation
   logic [F:0]          lox_ff, lox_in;       // lower bits shifted out
   logic [W-1:0]        accp_ff, accp_in;     // upper part of (1 - gain) * p1
   logic [F:0]          lop_ff, lop_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0] rsp_est_ff, rsp_est_in;
   logic                rsp_sat_ff, rsp_sat_in;

   // ---------------------------------------------------------------- csr port
   logic          csr_write;
   reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[CSR_AW-1:CSR_AW-REG_INDEX_WIDTH];

   always_comb begin
      q_in      = q_ff;
      r_in      = r_ff;
      init_x_in = init_x_ff;
      init_p_in = init_p_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_PROCESS_NOISE:     q_in      = csr_pwdata[W-1:0];
            REG_MEASUREMENT_NOISE: r_in      = csr_pwdata[W-1:0];
            REG_INITIAL_ESTIMATE:  init_x_in = csr_pwdata[W-1:0];
            REG_INITIAL_ERROR:     init_p_in = csr_pwdata[W-1:0];
            default:               q_in      = q_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_PROCESS_NOISE:     csr_prdata = CSR_DW'(q_ff);
         REG_MEASUREMENT_NOISE: csr_prdata = CSR_DW'(r_ff);
         REG_INITIAL_ESTIMATE:  csr_prdata = CSR_DW'(init_x_ff);
         REG_INITIAL_ERROR:     csr_prdata = CSR_DW'(init_p_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- handshakes
   logic req_beat;
   logic out_free;

   assign req_if.ready    = (state_ff == S_IDLE);
   assign req_beat        = req_if.valid & req_if.ready;
   assign out_free        = ~rsp_valid_ff | rsp_if.ready;
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.estimate = rsp_est_ff;
   assign rsp_if.saturated = rsp_sat_ff;

   // ---------------------------------------------------------------- step logic
   // prediction: first beat after reset takes the initial values
   logic signed [W-1:0] x_eff;
   logic [W-1:0]        p_eff;
   logic [W:0]          p1_sum;

   assign x_eff  = started_ff ? x_ff : init_x_ff;
   assign p_eff  = started_ff ? p_ff : init_p_ff;
   assign p1_sum = {1'b0, p_eff} + {1'b0, q_ff};

   // one restoring division step
   logic [W+1:0] rem_sh;
   logic [W+1:0] rem_diff;
   logic         q_bit;

   assign rem_sh   = {rem_ff, 1'b0};
   assign rem_diff = rem_sh - {1'b0, den_ff};
   assign q_bit    = (rem_sh >= {1'b0, den_ff});

   // one shift-add multiply step for both products
   logic signed [W+1:0] sx;
   logic [W:0]          sp;

   assign sx = accx_ff + (gain_ff[0] ? {inn_ff[W], inn_ff} : '0);
   assign sp = {1'b0, accp_ff} + (comp_ff[0] ? {1'b0, p1_ff} : '0);

   // final estimate with clamp to the signed range
   logic signed [W+2:0] delta;
   logic signed [W+2:0] xsum;
   logic                x_hi;
   logic                x_lo;
   logic signed [W-1:0] x_new;
   logic [W:0]          p_new;

   assign delta = {accx_ff, lox_ff[F]};
   assign xsum  = {{3{x_ff[W-1]}}, x_ff} + delta;
   assign x_hi  = ~xsum[W+2] & (xsum[W+1:W-1] != 3'b000);
   assign x_lo  = xsum[W+2] & (xsum[W+1:W-1] != 3'b111);
   assign p_new = {accp_ff, lop_ff[F]};

   always_comb begin
      if (x_hi) begin
         x_new = {1'b0, {(W-1){1'b1}}};
      end else if (x_lo) begin
         x_new = {1'b1, {(W-1){1'b0}}};
      end else begin
         x_new = xsum[W-1:0];
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      started_in   = started_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      p1_in        = p1_ff;
      sat_in       = sat_ff;
      inn_in       = inn_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      gain_in      = gain_ff;
      comp_in      = comp_ff;
      cnt_in       = cnt_ff;
      accx_in      = accx_ff;
      lox_in       = lox_ff;
      accp_in      = accp_ff;
      lop_in       = lop_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_if.ready;
      rsp_est_in   = rsp_est_ff;
      rsp_sat_in   = rsp_sat_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               // covariance grows by q, saturating
               started_in = 1'b1;
               x_in       = x_eff;
               sat_in     = p1_sum[W];
               p1_in      = p1_sum[W] ? {W{1'b1}} : p1_sum[W-1:0];
               inn_in     = {req_if.measurement[W-1], req_if.measurement}
                            - {x_eff[W-1], x_eff};
               state_in   = S_DEN;
            end
         end
         S_DEN: begin
            // gain is 0 when p1 + r is 0, exactly 1.0 when r is 0
            den_in  = {1'b0, p1_ff} + {1'b0, r_ff};
            rem_in  = {1'b0, p1_ff};
            cnt_in  = '0;
            if (r_ff == '0) begin
               gain_in  = (p1_ff == '0) ? '0 : GAIN_ONE;
               state_in = S_MSET;
            end else begin
               gain_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // one quotient bit per cycle
            rem_in  = q_bit ? rem_diff[W:0] : rem_sh[W:0];
            gain_in = {gain_ff[F-1:0], q_bit};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CW'(F - 1)) begin
               state_in = S_MSET;
            end
         end
         S_MSET: begin
            comp_in  = GAIN_ONE - gain_ff;
            accx_in  = '0;
            lox_in   = '0;
            accp_in  = '0;
            lop_in   = '0;
            cnt_in   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            // lsb-first shift-add, products shift right one bit a cycle
            accx_in = {sx[W+1], sx[W+1:1]};
            lox_in  = {sx[0], lox_ff[F:1]};
            accp_in = sp[W:1];
            lop_in  = {sp[0], lop_ff[F:1]};
            gain_in = {1'b0, gain_ff[F:1]};
            comp_in = {1'b0, comp_ff[F:1]};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CW'(F)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // hold until the output register is free
            if (out_free) begin
               x_in         = x_new;
               p_in         = p_new[W-1:0];
               rsp_valid_in = 1'b1;
               rsp_est_in   = x_new;
               rsp_sat_in   = sat_ff | x_hi | x_lo;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         q_ff         <= W'(PROCESS_NOISE_RESET);
         r_ff         <= W'(MEASUREMENT_NOISE_RESET);
         init_x_ff    <= W'(INITIAL_ESTIMATE_RESET);
         init_p_ff    <= W'(INITIAL_ERROR_RESET);
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         init_x_ff    <= init_x_in;
         init_p_ff    <= init_p_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      p_ff       <= p_in;
      p1_ff      <= p1_in;
      sat_ff     <= sat_in;
      inn_ff     <= inn_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      gain_ff    <= gain_in;
      comp_ff    <= comp_in;
      cnt_ff     <= cnt_in;
      accx_ff    <= accx_in;
      lox_ff     <= lox_in;
      accp_ff    <= accp_in;
      lop_ff     <= lop_in;
      rsp_est_ff <= rsp_est_in;
      rsp_sat_ff <= rsp_sat_in;
   end

endmodule

FILE: verif/skf_estimate_checker.sv
`timescale 1ns / 1ps

module skf_estimate_checker (
   input  logic        clock,
   input  logic        reset,
   skf_req_if          req_if,
   skf_rsp_if          rsp_if,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          failures,
   output int          outstanding
);
   import skf_pkg::*;

   localparam int DW = DATA_WIDTH_DEFAULT;
   localparam int FB = FRAC_BITS_DEFAULT;
   localparam longint unsigned GAIN_ONE = longint'(1) << FB;
   localparam longint unsigned COV_MAX  = (longint'(1) << DW) - 1;
   localparam longint EST_MAX = (longint'(1) << (DW - 1)) - 1;
   localparam longint EST_MIN = -EST_MAX - 1;

   typedef struct packed {
      logic signed [DW-1:0] estimate;
      logic                 saturated;
   } filter_output_type;

   // register copies
   logic [DW-1:0] q_noise;
   logic [DW-1:0] r_noise;
   logic [DW-1:0] start_estimate;
   logic [DW-1:0] start_covariance;

   // filter state
   longint          est_state;
   longint unsigned cov_state;
   bit              filter_started;

   filter_output_type expected_estimates[$];
   int                mismatch_count = 0;
   int                queued_count = 0;

   assign failures    = mismatch_count;
   assign outstanding = queued_count;

   function automatic filter_output_type kalman_step(input logic signed [DW-1:0] measurement);
      longint unsigned   cov_pred;
      longint unsigned   noise_sum;
      longint unsigned   gain;
      longint            correction;
      longint            next_est;
      filter_output_type result;
      if (!filter_started) begin
         est_state      = longint'($signed(start_estimate));
         cov_state      = longint'(start_covariance);
         filter_started = 1'b1;
      end
      result.saturated = 1'b0;
      cov_pred = cov_state + longint'(q_noise);
      if (cov_pred > COV_MAX) begin
         cov_pred         = COV_MAX;
         result.saturated = 1'b1;
      end
      noise_sum = cov_pred + longint'(r_noise);
      if (noise_sum == 0) begin
         gain = 0;
      end else if (cov_pred >= noise_sum) begin
         gain = GAIN_ONE;
      end else begin
         gain = (cov_pred << FB) / noise_sum;
      end
      // exact product, arithmetic shift rounds toward minus infinity
      correction = (longint'(gain) * (longint'(measurement) - est_state)) >>> FB;
      next_est   = est_state + correction;
      if (next_est > EST_MAX) begin
         next_est         = EST_MAX;
         result.saturated = 1'b1;
      end else if (next_est < EST_MIN) begin
         next_est         = EST_MIN;
         result.saturated = 1'b1;
      end
      cov_state       = ((GAIN_ONE - gain) * cov_pred) >> FB;
      est_state       = next_est;
      result.estimate = next_est[DW-1:0];
      return result;
   endfunction

   always @(posedge clock) begin
      filter_output_type oldest;
      if (reset) begin
         q_noise          = PROCESS_NOISE_RESET[DW-1:0];
         r_noise          = MEASUREMENT_NOISE_RESET[DW-1:0];
         start_estimate   = INITIAL_ESTIMATE_RESET[DW-1:0];
         start_covariance = INITIAL_ERROR_RESET[DW-1:0];
         est_state        = 0;
         cov_state        = 0;
         filter_started   = 1'b0;
         expected_estimates.delete();
      end else begin
         // a beat taken at the same edge as a register write sees the old value
         if (req_if.valid && req_if.ready) begin
            expected_estimates.push_back(kalman_step(req_if.measurement));
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_PROCESS_NOISE:     q_noise          = csr_pwdata;
               REG_MEASUREMENT_NOISE: r_noise          = csr_pwdata;
               REG_INITIAL_ESTIMATE:  start_estimate   = csr_pwdata;
               REG_INITIAL_ERROR:     start_covariance = csr_pwdata;
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_estimates.size() == 0) begin
               $error("result beat with nothing outstanding: estimate %0d, saturated %0b",
                      rsp_if.estimate, rsp_if.saturated);
               mismatch_count++;
            end else begin
               oldest = expected_estimates.pop_front();
               if (rsp_if.estimate !== oldest.estimate) begin
                  $error("estimate: expected %0d, actual %0d", oldest.estimate,
                         rsp_if.estimate);
                  mismatch_count++;
               end
               if (rsp_if.saturated !== oldest.saturated) begin
                  $error("saturated: expected %0b, actual %0b", oldest.saturated,
                         rsp_if.saturated);
                  mismatch_count++;
               end
            end
         end
      end
      queued_count = expected_estimates.size();
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import skf_pkg::*;

   // per-item idle draws go from 0 up to this
   localparam int unsigned MAX_GAP = 18;
   // result side holds off this long once, to back the filter up
   localparam int unsigned LONG_HOLD = 400;
   // a little more than the filter's latency at Q16.16
   localparam int unsigned LATENCY_MARGIN = 40;
   // worst honest quiet stretch is the long hold or a stalled result plus a full
   // item between the longest idle draws; take several times the larger
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES = 10;
   localparam int ITEMS_PER_PHASE = 63;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          failures;
   int          outstanding;
   int unsigned req_gap_max = MAX_GAP;
   int unsigned rsp_gap_max = MAX_GAP;
   bit          long_hold_request = 1'b0;
   int unsigned quiet_cycles = 0;

   skf_req_if req_bus ();
   skf_rsp_if rsp_bus ();

   scalar_kalman_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   skf_estimate_checker estimate_monitor (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // apb write: setup cycle, then access cycle until pready;
   // psel is left high so back-to-back writes never lower and raise it in one step
   task automatic write_register(input reg_index_type index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   // all four registers every time, then release the bus
   task automatic configure(input logic [31:0] q, input logic [31:0] r,
                            input logic [31:0] x0, input logic [31:0] p0);
      write_register(REG_PROCESS_NOISE, q);
      write_register(REG_MEASUREMENT_NOISE, r);
      write_register(REG_INITIAL_ESTIMATE, x0);
      write_register(REG_INITIAL_ERROR, p0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // one measurement beat, after a random idle stretch
   task automatic send_measurement(input logic [31:0] value);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.measurement <= value;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
   endtask

   // stop offering, let every expected estimate come back, then let the
   // filter go quiet before the registers are touched
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (LATENCY_MARGIN) @(posedge clock);
   endtask

   // noise variances: zero, full scale, small, or anything
   function automatic logic [31:0] draw_noise();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(0, 32'h0004_0000);
         default: return $urandom();
      endcase
   endfunction

   // mostly a noisy sensor around a centre, some wild values and extremes
   function automatic logic [31:0] draw_measurement(input logic [31:0] centre);
      logic [31:0] jitter;
      jitter = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return '0;
               default: return '1;
            endcase
         end
         1, 2, 3: return $urandom();
         default: return centre + jitter;
      endcase
   endfunction

   // result side: random hold-offs per beat, plus one long hold on request
   initial begin
      int unsigned gap;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = $urandom_range(0, rsp_gap_max);
         if (long_hold_request) begin
            gap = LONG_HOLD;
            long_hold_request = 1'b0;
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // watchdog: any beat or register access counts as progress
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] centre;
      reset               <= 1'b1;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.measurement <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // start from the most negative estimate and full covariance; q at full
      // scale overflows the prediction, r of zero makes the gain exactly one
      configure('1, '0, 32'h8000_0000, '1);
      send_measurement(32'h7FFF_FFFF);
      send_measurement(32'h8000_0000);
      send_measurement(32'h0000_0000);
      send_measurement(32'hFFFF_FFFF);
      drain_results();

      // covariance is now zero: with q and r both zero the gain denominator
      // vanishes and the estimate must stay put
      configure('0, '0, 32'h7FFF_FFFF, '0);
      send_measurement(32'h7FFF_FFFF);
      send_measurement(32'h0000_0001);
      send_measurement(32'h8000_0000);
      drain_results();

      // register defaults, small gain against full-range innovations
      configure(32'd655, 32'd65536, '0, 32'd65536);
      send_measurement(32'h7FFF_FFFF);
      send_measurement(32'h8000_0000);
      send_measurement(32'h0001_0000);
      send_measurement(32'hFFFF_0000);
      send_measurement(32'h0000_0000);
      send_measurement(32'h7FFF_FFFF);
      drain_results();

      // both noises at full scale: prediction overflows, gain of one half,
      // estimate swings halfway toward each end of the range
      configure('1, '1, 32'h0000_0001, 32'hFFFF_FFFE);
      send_measurement(32'h7FFF_FFFF);
      send_measurement(32'h8000_0000);
      send_measurement(32'h7FFF_FFFF);
      send_measurement(32'h8000_0000);
      drain_results();

      // no process noise and the smallest measurement noise
      configure('0, 32'd1, $urandom(), $urandom());
      send_measurement(32'h0000_0000);
      send_measurement(32'h8000_0000);
      send_measurement(32'h7FFF_FFFF);
      drain_results();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         configure(draw_noise(), draw_noise(), $urandom(), $urandom());
         // some phases run without idling on one side or both
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
         if (phase == 0) begin
            // back-pressure: results held off while beats keep coming
            req_gap_max       = 0;
            long_hold_request = 1'b1;
         end
         centre = $urandom();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_measurement(draw_measurement(centre));
         end
         drain_results();
      end

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: scalar_kalman_filter.f
hdl/skf_pkg.sv
hdl/skf_req_if.sv
hdl/skf_rsp_if.sv
hdl/scalar_kalman_filter.sv
verif/skf_estimate_checker.sv
verif/testbench.sv
